// ----- rtl/gee_pkg.sv -----
// Shared types and constants for the GPIO edge-event detector.
// Depends on nothing; gee_detect, gee_drain and the top level import it.
`default_nettype none
package gee_pkg;

	localparam int PORT_W = 8;
	localparam int PIN_W  = 3;
	localparam int CFG_W  = 8;
	localparam int CFG_IDX_W = 2;

	// Operation codes
	typedef enum logic {
		OP_SEED = 1'b0,
		OP_POLL = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_A = 2'd0,
		REG_RISING_A = 2'd1,
		REG_ENABLE_B = 2'd2,
		REG_RISING_B = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              op;
		logic              port;
		logic [PORT_W-1:0] sample;
		logic              read_ok;
	} in_item_t;

	typedef struct packed {
		logic [PIN_W-1:0] pin;
		logic             rising;
		logic             event_port;
		logic             last;
	} out_item_t;

	// Event set handed from the detector to the drain stage
	typedef struct packed {
		logic              load;
		logic              port;
		logic [PORT_W-1:0] fire;
		logic [PORT_W-1:0] sample;
	} event_set_t;

endpackage
`default_nettype wire

// ----- rtl/gee_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Used for both the sample input and the event output.
`default_nettype none
interface gee_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/gee_detect.sv -----
// Configuration registers, previous-value registers and edge detection.
// Depends on gee_pkg.
`default_nettype none
module gee_detect
	import gee_pkg::*;
#(
	parameter int PINS_PER_PORT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 accept,
	input  in_item_t             item,
	output event_set_t           events
);

	localparam int LIMIT = (PINS_PER_PORT < PORT_W) ? PINS_PER_PORT : PORT_W;
	localparam logic [PORT_W-1:0] VALID_PINS = PORT_W'((64'd1 << LIMIT) - 64'd1);

	logic [PORT_W-1:0] enable_a_q, rising_a_q, enable_b_q, rising_b_q;
	logic [PORT_W-1:0] previous_a_q, previous_b_q;
	logic [PORT_W-1:0] prev, en, pol, fire;
	logic              is_poll, update;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_a_q <= '0;
			rising_a_q <= '0;
			enable_b_q <= '0;
			rising_b_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ENABLE_A: enable_a_q <= cfg_data;
				REG_RISING_A: rising_a_q <= cfg_data;
				REG_ENABLE_B: enable_b_q <= cfg_data;
				REG_RISING_B: rising_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select the port's state and find pins that fire
	always_comb begin
		prev    = item.port ? previous_b_q : previous_a_q;
		en      = item.port ? enable_b_q : enable_a_q;
		pol     = item.port ? rising_b_q : rising_a_q;
		is_poll = (op_t'(item.op) == OP_POLL);
		fire    = (prev ^ item.sample) & en & ~(pol ^ item.sample) & VALID_PINS;
		update  = accept && item.read_ok && (!is_poll || (en != '0));
	end

	// Hold the previous sample per port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_a_q <= '0;
			previous_b_q <= '0;
		end else if (update) begin
			if (item.port)
				previous_b_q <= item.sample;
			else
				previous_a_q <= item.sample;
		end
	end

	assign events.load   = accept && item.read_ok && is_poll;
	assign events.port   = item.port;
	assign events.fire   = fire;
	assign events.sample = item.sample;

endmodule
`default_nettype wire

// ----- rtl/gee_drain.sv -----
// Pending-event register and output register: emits one event per cycle while out_ready holds.
// Depends on gee_pkg.
`default_nettype none
module gee_drain
	import gee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  event_set_t events,
	output logic       take_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output out_item_t  out_item
);

	logic [PORT_W-1:0] fire_s1, sample_s1;
	logic              port_s1;
	logic              valid_q;
	out_item_t         item_q;
	logic [PORT_W-1:0] lowest, remaining;
	logic [PIN_W-1:0]  pin_idx;
	logic              emit;

	// Pick the lowest pending pin
	always_comb begin
		lowest    = fire_s1 & (~fire_s1 + PORT_W'(1));
		remaining = fire_s1 & ~lowest;
		pin_idx   = '0;
		for (int i = 0; i < PORT_W; i++) begin
			if (lowest[i])
				pin_idx = pin_idx | PIN_W'(i);
		end
		emit       = (fire_s1 != '0) && (!valid_q || out_ready);
		take_ready = (fire_s1 == '0) || (emit && (remaining == '0));
	end

	// Advance the pending set; a new transfer loads once it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_s1 <= '0;
		end else if (events.load) begin
			fire_s1 <= events.fire;
		end else if (emit) begin
			fire_s1 <= remaining;
		end
	end

	always_ff @(posedge clk) begin
		if (events.load) begin
			sample_s1 <= events.sample;
			port_s1   <= events.port;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			item_q.pin        <= pin_idx;
			item_q.rising     <= |(sample_s1 & lowest);
			item_q.event_port <= port_s1;
			item_q.last       <= (remaining == '0);
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
`default_nettype wire

// ----- rtl/gpio_edge_event_detector.sv -----
// Top level of the GPIO edge-event detector for two 8-pin ports.
// Depends on gee_pkg, gee_stream_if, gee_detect and gee_drain.
//
// Each input transfer seeds or polls one port; a poll yields one event per
// changed, enabled pin of the right polarity, lowest pin first, the final one
// flagged last. Events leave through the output register at one per cycle
// while out_ready is high; the next input is taken in the cycle its
// predecessor's last event enters the output register. The pending-event
// register and its lowest-bit pick set this rate. Seeds and failed reads
// emit nothing.
`default_nettype none
module gpio_edge_event_detector
	import gee_pkg::*;
#(
	parameter int PINS_PER_PORT = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gee_stream_if.sink           in_stream,
	gee_stream_if.source         out_stream,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	event_set_t events;
	logic       take_ready;
	logic       accept;
	in_item_t   item;
	out_item_t  result;

	assign item      = in_stream.payload;
	assign accept    = in_stream.valid && take_ready;
	assign in_stream.ready = take_ready;

	gee_detect #(
		.PINS_PER_PORT(PINS_PER_PORT)
	) u_detect (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.item     (item),
		.events   (events)
	);

	gee_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (events),
		.take_ready(take_ready),
		.out_ready (out_stream.ready),
		.out_valid (out_stream.valid),
		.out_item  (result)
	);

	assign out_stream.payload = result;

endmodule
`default_nettype wire
